// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== hdl/rmb_pkg.sv =====
// Types, constants and lane arithmetic for the RGBA mip box downsampler.
package rmb_pkg;

  localparam int PIX_W        = 32;
  localparam int LANES        = 4;
  localparam int LANE_W       = 8;
  localparam int SUM_W        = 9;
  localparam int SUMS_W       = LANES * SUM_W;
  localparam int ALPHA_LANE   = 3;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd256;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd256;
  localparam logic [LANE_W-1:0]       ALPHA_MAX    = 8'd255;

  // One entry of the command queue between front and back.
  typedef struct packed {
    logic              store;  // even row: write pair sums to the line store
    logic              last;   // final result of the frame
    logic [SUMS_W-1:0] sums;   // four 9-bit horizontal pair sums
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic             frame_last;
    logic [PIX_W-1:0] pixel;
  } out_t;

  // Per-lane sums of two horizontally adjacent pixels.
  function automatic logic [SUMS_W-1:0] pair_sums(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
    logic [SUMS_W-1:0] r;
    r = '0;
    for (int lane = 0; lane < LANES; lane++) begin
      r[lane*SUM_W +: SUM_W] = {1'b0, a[lane*LANE_W +: LANE_W]} +
                               {1'b0, b[lane*LANE_W +: LANE_W]};
    end
    return r;
  endfunction

  // Adds top and bottom pair sums; color lanes average, alpha gets a 1/8 boost.
  function automatic logic [PIX_W-1:0] combine(input logic [SUMS_W-1:0] top,
                                               input logic [SUMS_W-1:0] bottom);
    logic [PIX_W-1:0] r;
    logic [SUM_W:0]   s;
    logic [SUM_W+1:0] boost;
    logic [SUM_W-1:0] q;
    r = '0;
    for (int lane = 0; lane < LANES; lane++) begin
      s = {1'b0, top[lane*SUM_W +: SUM_W]} + {1'b0, bottom[lane*SUM_W +: SUM_W]};
      boost = {1'b0, s} + {4'b0, s[SUM_W:3]};
      q = boost[SUM_W+1:2];
      if (lane == ALPHA_LANE) begin
        r[lane*LANE_W +: LANE_W] = (q > {1'b0, ALPHA_MAX}) ? ALPHA_MAX : q[LANE_W-1:0];
      end else begin
        r[lane*LANE_W +: LANE_W] = s[SUM_W:2];
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/rgba_mip_box_downsample.sv =====
// Top level of the 2x2 box-filter RGBA mipmap downsampler.
// Accepts one 32-bit pixel per clock in raster order unless full, and returns
// one half-resolution pixel per 2x2 block, one result at most per clock. A
// result passes from the pixel that completes its block through the command
// queue, then the line-store read with the combine feeding the result queue.
// The sustained rate is one pixel per cycle unless the result queue fills; the
// single line-store port does one write (even rows) or one read (odd rows) for
// every pixel pair. A four-entry command queue parts the intake from the
// line-store side, and a four-entry result queue parts the line-store side from
// the consumer. Writing either register restarts the frame; the user must write
// registers only while the block is idle, which the block itself does not enforce.
`include "assert_macros.svh"

module rgba_mip_box_downsample import rmb_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [PIX_W-1:0]       pixel_word,
  output logic                   empty,
  input  logic                   pop,
  output logic [PIX_W-1:0]       mip_pixel,
  output logic                   frame_last
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CMD_DEPTH  = 4;
  localparam int OUT_DEPTH  = 4;
  localparam int CMD_W      = ADDR_W + $bits(cmd_t);

  logic                              cmd_push;
  logic                              cmd_full;
  cmd_t                              cmd_in;
  logic [ADDR_W-1:0]                 idx_in;
  logic                              cmd_pop;
  logic                              cmd_empty;
  logic [CMD_W-1:0]                  cmd_q;
  cmd_t                              cmd_out;
  logic [ADDR_W-1:0]                 idx_out;
  logic                              out_push;
  logic                              out_full;
  out_t                              out_in;
  out_t                              out_q;
  logic [$clog2(OUT_DEPTH+1)-1:0]    out_level;

  // Intake and pairing.
  rmb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .pixel_word (pixel_word),
    .cmd_push   (cmd_push),
    .cmd_full   (cmd_full),
    .cmd        (cmd_in),
    .cmd_idx    (idx_in)
  );

  // Command queue between front and back.
  rmb_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata ({idx_in, cmd_in}),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_q),
    .empty (cmd_empty),
    .level ()
  );

  assign idx_out = cmd_q[CMD_W-1 -: ADDR_W];
  assign cmd_out = cmd_q[$bits(cmd_t)-1:0];

  // Line store and combine.
  rmb_back #(.MAX_WIDTH(MAX_WIDTH), .OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_idx   (idx_out),
    .cmd_pop   (cmd_pop),
    .out_level (out_level),
    .out_push  (out_push),
    .out_data  (out_in)
  );

  // Result queue toward the consumer.
  rmb_fifo #(.WIDTH($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_q),
    .empty (empty),
    .level (out_level)
  );

  assign mip_pixel  = out_q.pixel;
  assign frame_last = out_q.frame_last;

  // The back end reserves a result slot before it starts a line-store read.
  `ASSERT_NEVER(a_out_no_overflow, clk, rst, out_push && out_full, "result queue overflow")

  // The front end only issues a command when the queue has room.
  `ASSERT_NEVER(a_cmd_no_overflow, clk, rst, cmd_push && cmd_full, "command queue overflow")

  // A line-store write never produces a result.
  `ASSERT_HOLDS(a_store_no_result, clk, rst, (cmd_pop && cmd_out.store) |=> !out_push,
                "result after a store command")

endmodule

// ===== hdl/rmb_fifo.sv =====
// Small register-based first-in first-out queue with a fill level.
module rmb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign level   = count;
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage is written without reset; only the pointers and the count are control state.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rmb_front.sv =====
// Front end: pixel intake, raster position, pairing and command issue.
module rmb_front import rmb_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     push,
  output logic                     full,
  input  logic [PIX_W-1:0]         pixel_word,
  output logic                     cmd_push,
  input  logic                     cmd_full,
  output cmd_t                     cmd,
  output logic [((MAX_WIDTH/2 > 1) ? $clog2(MAX_WIDTH/2) : 1)-1:0] cmd_idx
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W      = ((COL_W > WIDTH_REG_W) ? COL_W : WIDTH_REG_W) + 1;
  localparam int WIDTH_LIM  = MAX_WIDTH - (MAX_WIDTH % 2);

  logic [WIDTH_REG_W-1:0]  eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [COL_W-1:0]        column_count;
  logic [HEIGHT_REG_W-1:0] row_count;
  logic [PIX_W-1:0]        held_left_pixel;
  logic                    accept;
  logic                    col_end;
  logic                    row_end;

  // Even width, clamped to the line store, never below two.
  function automatic logic [WIDTH_REG_W-1:0] width_of(input logic [WIDTH_REG_W-1:0] raw);
    logic [WIDTH_REG_W-1:0] w;
    w = {raw[WIDTH_REG_W-1:1], 1'b0};
    if (int'(w) > WIDTH_LIM) begin
      w = WIDTH_REG_W'(WIDTH_LIM);
    end
    if (w == '0) begin
      w = WIDTH_REG_W'(2);
    end
    return w;
  endfunction

  // Even height, never below two.
  function automatic logic [HEIGHT_REG_W-1:0] height_of(input logic [HEIGHT_REG_W-1:0] raw);
    logic [HEIGHT_REG_W-1:0] h;
    h = {raw[HEIGHT_REG_W-1:1], 1'b0};
    if (h == '0) begin
      h = HEIGHT_REG_W'(2);
    end
    return h;
  endfunction

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign col_end  = (CMP_W'(column_count) + 1'b1) >= CMP_W'(eff_w);
  assign row_end  = ({1'b0, row_count} + 1'b1) >= {1'b0, eff_h};

  // A command goes out on every odd column.
  assign cmd_push  = accept && column_count[0];
  assign cmd.store = !row_count[0];
  assign cmd.last  = col_end && row_end;
  assign cmd.sums  = pair_sums(held_left_pixel, pixel_word);
  assign cmd_idx   = ADDR_W'(column_count >> 1);

  // Effective dimensions are settled when a register is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= width_of(WIDTH_RESET);
      eff_h <= height_of(HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  eff_w <= width_of(cfg_data[WIDTH_REG_W-1:0]);
        REG_IMAGE_HEIGHT: eff_h <= height_of(cfg_data[HEIGHT_REG_W-1:0]);
        default: ;
      endcase
    end
  end

  // Raster position and held left pixel; a register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      column_count    <= '0;
      row_count       <= '0;
      held_left_pixel <= '0;
    end else if (accept) begin
      if (!column_count[0]) begin
        held_left_pixel <= pixel_word;
      end
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rmb_back.sv =====
// Back end: line store access, vertical combine and result issue.
module rmb_back import rmb_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int OUT_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_empty,
  input  cmd_t                     cmd,
  input  logic [((MAX_WIDTH/2 > 1) ? $clog2(MAX_WIDTH/2) : 1)-1:0] cmd_idx,
  output logic                     cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
  output logic                     out_push,
  output out_t                     out_data
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LVL_W      = $clog2(OUT_DEPTH+1) + 1;

  logic [SUMS_W-1:0] line_mem [LINE_DEPTH];
  logic [SUMS_W-1:0] top_sums;
  logic [SUMS_W-1:0] s1_sums;
  logic              s1_last;
  logic              s1_valid;
  logic              room;

  // A read command needs a free result slot, counting the one in flight.
  assign room    = (LVL_W'(out_level) + LVL_W'(s1_valid)) < LVL_W'(OUT_DEPTH);
  assign cmd_pop = !cmd_empty && (cmd.store || room);

  // Line store: one write or one registered read per cycle while commands are popped.
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.store) begin
      line_mem[cmd_idx] <= cmd.sums;
    end
    if (cmd_pop && !cmd.store) begin
      top_sums <= line_mem[cmd_idx];
    end
  end

  // Bottom pair sums travel alongside the memory read.
  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd.store) begin
      s1_sums <= cmd.sums;
      s1_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop && !cmd.store;
    end
  end

  // Vertical combine feeds the result queue directly.
  assign out_push            = s1_valid;
  assign out_data.pixel      = combine(top_sums, s1_sums);
  assign out_data.frame_last = s1_last;

endmodule

// ===== dv/tb_rgba_mip_box_downsample.sv =====
// Self-checking testbench for the RGBA 2x2 box-filter mipmap downsampler.
module tb_rgba_mip_box_downsample;
  import rmb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX_WIDTH = 2048;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [PIX_W-1:0]       pixel_word = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [PIX_W-1:0]       mip_pixel;
  logic                   frame_last;

  // Shadow copy of the block's configuration and stream position.
  logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  logic [SUMS_W-1:0]       pair_line [LINE_MAX_WIDTH/2];
  logic [PIX_W-1:0]        left_pixel = '0;
  int                      col_pos = 0;
  int                      row_pos = 0;

  out_t mip_expected[$];
  out_t want;
  int   error_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 20;
  int   recv_idle_pct = 57;

  rgba_mip_box_downsample #(.MAX_WIDTH(LINE_MAX_WIDTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .pixel_word (pixel_word),
    .empty      (empty),
    .pop        (pop),
    .mip_pixel  (mip_pixel),
    .frame_last (frame_last)
  );

  always #1 clk = ~clk;

  // Run limit in case the block stops producing results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, mip_expected.size());
      $display("** rgba_mip_box_downsample: FAILED **");
      $finish;
    end
  end

  // Consumer: pops at random with the current idle rate.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each popped transaction with the oldest predicted result.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (mip_expected.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected: mip_pixel %08h frame_last %0b",
                 $time, mip_pixel, frame_last);
      end else begin
        want = mip_expected.pop_front();
        if (mip_pixel !== want.pixel) begin
          error_count++;
          $display("%0t: mip_pixel expected %08h actual %08h", $time, want.pixel, mip_pixel);
        end
        if (frame_last !== want.frame_last) begin
          error_count++;
          $display("%0t: frame_last expected %0b actual %0b", $time, want.frame_last,
                   frame_last);
        end
      end
    end
  end

  function automatic int active_width();
    int w;
    w = width_reg & 12'hFFE;
    if (w > LINE_MAX_WIDTH) w = LINE_MAX_WIDTH;
    if (w == 0) w = 2;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = height_reg & 16'hFFFE;
    if (h == 0) h = 2;
    return h;
  endfunction

  // Advance the shadow stream by one pixel and queue the result it completes.
  function automatic void predict_pixel(input logic [PIX_W-1:0] px);
    int          w;
    int          h;
    int          idx;
    int          s;
    int          v;
    logic [SUMS_W-1:0] bottom;
    out_t        item;
    w = active_width();
    h = active_height();
    idx = col_pos >> 1;
    if (idx >= LINE_MAX_WIDTH / 2) idx = LINE_MAX_WIDTH / 2 - 1;
    if ((col_pos & 1) == 0) begin
      left_pixel = px;
    end else begin
      for (int lane = 0; lane < LANES; lane++) begin
        bottom[lane*SUM_W +: SUM_W] = {1'b0, left_pixel[lane*LANE_W +: LANE_W]} +
                                      {1'b0, px[lane*LANE_W +: LANE_W]};
      end
      if ((row_pos & 1) == 0) begin
        pair_line[idx] = bottom;
      end else begin
        item = '0;
        for (int lane = 0; lane < LANES; lane++) begin
          s = pair_line[idx][lane*SUM_W +: SUM_W];
          s = s + bottom[lane*SUM_W +: SUM_W];
          if (lane == ALPHA_LANE) begin
            v = (s + s / 8) / 4;
            if (v > 255) v = 255;
          end else begin
            v = s / 4;
          end
          item.pixel[lane*LANE_W +: LANE_W] = v[7:0];
        end
        item.frame_last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        mip_expected.push_back(item);
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Offer one pixel after a random gap and wait until it is accepted.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    pixel_word <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_pixel(px);
  endtask

  // Stop sending and wait until every predicted result has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    while (mip_expected.size() != 0) @(posedge clk);
  endtask

  // Register write, only once the block has gone idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (index == REG_IMAGE_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
    else height_reg = data[HEIGHT_REG_W-1:0];
    left_pixel = '0;
    col_pos = 0;
    row_pos = 0;
  endtask

  // Random pixel, biased so that lanes often sit at 0 or 255.
  function automatic logic [PIX_W-1:0] draw_pixel();
    logic [PIX_W-1:0] px;
    px = $urandom();
    if ($urandom_range(1) == 0) begin
      for (int lane = 0; lane < LANES; lane++) begin
        case ($urandom_range(3))
          0: px[lane*LANE_W +: LANE_W] = 8'h00;
          1: px[lane*LANE_W +: LANE_W] = 8'hFF;
          default: ;
        endcase
      end
    end
    return px;
  endfunction

  // Two rows at the reset size of 256 by 256, before any register write.
  task automatic test_reset_size();
    for (int i = 0; i < 512; i++) send_pixel(draw_pixel());
  endtask

  // Small frames: all-zero and all-one pixels, alpha on both sides of
  // saturation, frame wrap, zero dimensions and odd register values.
  task automatic test_directed();
    logic [PIX_W-1:0] frame_pix [16] = '{
      32'h00000000, 32'hFFFFFFFF, 32'hE4E4E4E4, 32'hE4E4E4E4,
      32'hFFFFFFFF, 32'h00000000, 32'hE4E4E4E4, 32'hE4E4E4E4,
      32'hE3E3E3E3, 32'hE3E3E3E3, 32'h01010101, 32'h02030405,
      32'hE3E3E3E3, 32'hE3E3E3E3, 32'h03030303, 32'hFFFFFFFF
    };
    logic [PIX_W-1:0] tiny_pix [4] = '{
      32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0
    };
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    foreach (frame_pix[i]) send_pixel(frame_pix[i]);
    // Register values 1 and 0 both fall back to two.
    write_reg(REG_IMAGE_WIDTH, 16'd1);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    foreach (tiny_pix[i]) send_pixel(tiny_pix[i]);
    // Odd values lose their lowest bit.
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    foreach (tiny_pix[i]) send_pixel(~tiny_pix[i]);
  endtask

  // Widest and tallest setting: all register bits set, so the width saturates;
  // only the start of the first row is sent.
  task automatic test_dimensions();
    write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    for (int i = 0; i < LINE_MAX_WIDTH / 8; i++) send_pixel(draw_pixel());
  endtask

  // Random small frames; a few are cut short so the next write restarts them.
  task automatic test_random_frames(input int n_items);
    int sent;
    int w;
    int h;
    int total;
    sent = 0;
    while (sent < n_items) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 16);
      h = $urandom_range(1, 8);
      write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(15)), 12'(w)});
      write_reg(REG_IMAGE_HEIGHT, 16'(h));
      total = $urandom_range(1, 2) * active_width() * active_height();
      if ($urandom_range(9) == 0) total = $urandom_range(1, total - 1);
      for (int i = 0; i < total; i++) begin
        // Now and then hold off mid-frame until the block has fully drained.
        if (i == total / 2 && (sent == 0 || $urandom_range(3) == 0)) wait_drained();
        send_pixel(draw_pixel());
      end
      sent += total;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_directed();
    test_dimensions();
    test_random_frames(140);

    send_idle_pct = 57;
    recv_idle_pct = 20;
    test_random_frames(140);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(140);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && mip_expected.size() == 0) begin
      $display("** rgba_mip_box_downsample: PASSED **");
    end else begin
      $display("** rgba_mip_box_downsample: FAILED **");
    end
    $finish;
  end

endmodule
